// ----- rtl/tiex_pkg.sv -----
// Shared types, codes and constants for the tiny instruction execute block.
`default_nettype none

package tiex_pkg;

    localparam int MEM_DEPTH_DEF  = 256;
    localparam int PROG_DEPTH_DEF = 1024;
    localparam int REG_COUNT_DEF  = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int PC_W       = 16;
    localparam int LEN_W      = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = 32;

    localparam logic [5:0] CYC_ALU  = 6'd1;
    localparam logic [5:0] CYC_HIT  = 6'd2;
    localparam logic [5:0] CYC_MISS = 6'd45;

    typedef enum logic [2:0] {
        FUNC_MOV     = 3'd0,
        FUNC_ADD_REG = 3'd1,
        FUNC_ADD_IMM = 3'd2,
        FUNC_CMP     = 3'd3,
        FUNC_JE      = 3'd4,
        FUNC_JMP     = 3'd5,
        FUNC_LD      = 3'd6,
        FUNC_ST      = 3'd7
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROG_START  = 1'b0,
        CFG_PROG_LENGTH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Instruction after decode, as it waits in the queue.
    typedef struct packed {
        t_func            func;
        logic [2:0]       reg_a;
        logic             ra_ok;
        logic [2:0]       reg_b;
        logic             rb_ok;
        logic [7:0]       imm;
        logic [PC_W-1:0]  target;
        logic             is_mem;
        logic             wr_reg;
    } t_dec_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- rtl/tiex_in_if.sv -----
// Instruction input channel.
`default_nettype none

interface tiex_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [2:0]        reg_a;
    logic [2:0]        reg_b;
    logic signed [7:0] immediate;
    logic [15:0]       jump_target;

    modport source (output valid, func, reg_a, reg_b, immediate, jump_target, input ready);
    modport sink   (input valid, func, reg_a, reg_b, immediate, jump_target, output ready);
endinterface

`default_nettype wire

// ----- rtl/tiex_out_if.sv -----
// Result output channel.
`default_nettype none

interface tiex_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic        halted;
    logic [31:0] executed_count;
    logic [31:0] cycle_total;
    logic [31:0] hit_count;
    logic [31:0] access_count;

    modport source (output valid, next_pc, halted, executed_count, cycle_total, hit_count,
                    access_count, input ready);
    modport sink   (input valid, next_pc, halted, executed_count, cycle_total, hit_count,
                    access_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/tiny_isa_execute_with_local_memory_top.sv -----
// Top level of the tiny instruction execute block with local memory.
//
//   Channel    Dir  Handshake     Payload
//   i_item     in   valid/ready   func, reg_a, reg_b, immediate, jump_target
//   o_result   out  valid/ready   next_pc, halted, executed_count, cycle_total,
//                                 hit_count, access_count
//   i_cfg_*    in   write enable  i_cfg_idx, i_cfg_data
//
// One instruction completes per cycle while results are taken; a load waits in execute
// because the local memory read is registered before the loaded byte is written back.
// Decoded instructions wait in a two-entry queue, so the front keeps taking instructions
// while a result waits in the output register, until the queue holds two; then ready drops.
// Reset is synchronous; memory valid marks live in flip-flops, so no clearing pass runs.
// Results stall execute only when the output register is full and not being taken.
`default_nettype none

module tiny_isa_execute_with_local_memory_top #(
    parameter int MEM_DEPTH  = tiex_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = tiex_pkg::PROG_DEPTH_DEF,
    parameter int REG_COUNT  = tiex_pkg::REG_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tiex_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tiex_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tiex_in_if.sink                         i_item,
    tiex_out_if.source                      o_result
);

    tiex_pkg::t_cfg_wr   cfg;
    tiex_pkg::t_dec_item dec;
    tiex_pkg::t_dec_item head;
    tiex_pkg::t_q_stat   q_stat;
    logic                push;
    logic                pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = tiex_pkg::t_cfg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    tiex_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .i_item   (i_item),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_dec    (dec)
    );

    tiex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tiex_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .PROG_DEPTH (PROG_DEPTH),
        .REG_COUNT  (REG_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_head    (head),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_result  (o_result)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue reports empty and full at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("execute retired an instruction from an empty queue");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_result.valid)
        else $error("retired instruction produced no result");

endmodule

`default_nettype wire

// ----- rtl/tiex_front.sv -----
// Front end: accepts instructions and decodes them for the queue.
`default_nettype none

module tiex_front #(
    parameter int REG_COUNT = tiex_pkg::REG_COUNT_DEF
) (
    tiex_in_if.sink              i_item,
    input  logic                 i_q_full,
    output logic                 o_push,
    output tiex_pkg::t_dec_item  o_dec
);

    localparam logic [3:0] REG_LIM = 4'(REG_COUNT);

    tiex_pkg::t_func func;
    logic            ra_ok;

    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    assign func  = tiex_pkg::t_func'(i_item.func);
    assign ra_ok = {1'b0, i_item.reg_a} < REG_LIM;

    always_comb begin
        o_dec.func   = func;
        o_dec.reg_a  = i_item.reg_a;
        o_dec.ra_ok  = ra_ok;
        o_dec.reg_b  = i_item.reg_b;
        o_dec.rb_ok  = {1'b0, i_item.reg_b} < REG_LIM;
        o_dec.imm    = i_item.immediate;
        o_dec.target = i_item.jump_target;
        o_dec.is_mem = 1'b0;
        o_dec.wr_reg = 1'b0;
        case (func)
            tiex_pkg::FUNC_MOV, tiex_pkg::FUNC_ADD_REG, tiex_pkg::FUNC_ADD_IMM: begin
                o_dec.wr_reg = ra_ok;
            end
            tiex_pkg::FUNC_LD: begin
                o_dec.wr_reg = ra_ok;
                o_dec.is_mem = 1'b1;
            end
            tiex_pkg::FUNC_ST: begin
                o_dec.is_mem = 1'b1;
            end
            default: begin
                o_dec.wr_reg = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tiex_queue.sv -----
// Short queue of decoded instructions between front end and execute.
`default_nettype none

module tiex_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tiex_pkg::t_dec_item  i_data,
    input  logic                 i_pop,
    output tiex_pkg::t_dec_item  o_head,
    output tiex_pkg::t_q_stat    o_stat
);

    localparam int DEPTH = tiex_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    tiex_pkg::t_dec_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULLC);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tiex_back.sv -----
// Execute stage: register file, local memory, program counter and statistics.
`default_nettype none

module tiex_back #(
    parameter int MEM_DEPTH  = tiex_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = tiex_pkg::PROG_DEPTH_DEF,
    parameter int REG_COUNT  = tiex_pkg::REG_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tiex_pkg::t_cfg_wr    i_cfg,
    input  tiex_pkg::t_dec_item  i_head,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    tiex_out_if.source           o_result
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int RW = $clog2(REG_COUNT);
    localparam int PW = tiex_pkg::PC_W;
    localparam int LW = tiex_pkg::LEN_W;
    localparam int CN = tiex_pkg::CNT_W;
    localparam logic [PW:0] PROG_LIM = (PW + 1)'(PROG_DEPTH);

    logic [PW-1:0] r_pc,    n_pc;
    logic [PW-1:0] r_start;
    logic [LW-1:0] r_len;
    logic [7:0]    r_rf [REG_COUNT];
    logic          r_eq;
    logic [7:0]    r_mem_data [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_valid;
    logic [MEM_DEPTH-1:0] r_mem_wr;
    logic [CN-1:0] r_exec, n_exec;
    logic [CN-1:0] r_cyc,  n_cyc;
    logic [CN-1:0] r_hit,  n_hit;
    logic [CN-1:0] r_acc,  n_acc;
    logic          r_ld_phase;
    logic [7:0]    r_ld_data;
    logic          r_out_valid;
    logic [PW-1:0] r_out_pc;
    logic          r_out_halted;
    logic [CN-1:0] r_out_exec, r_out_cyc, r_out_hit, r_out_acc;

    logic          live, is_ld, out_free, ld_issue, fire, running, hit;
    logic [7:0]    a_val, b_val, addr_src, ld_val, wdata;
    logic [AW-1:0] maddr;
    logic [PW-1:0] npc;
    logic [5:0]    cyc_add;

    // Program window test; the end is computed one bit wider so it cannot wrap.
    function automatic logic in_window(input logic [PW-1:0] addr, input logic [PW-1:0] start,
                                       input logic [LW-1:0] len);
        logic [PW:0] len_c;
        logic [PW:0] win_end;
        len_c   = {{(PW + 1 - LW){1'b0}}, len};
        len_c   = (len_c > PROG_LIM) ? PROG_LIM : len_c;
        win_end = {1'b0, start} + len_c;
        return (addr >= start) && ({1'b0, addr} < win_end);
    endfunction

    // Byte address reduced to the memory depth by a short restoring subtract chain.
    function automatic logic [AW-1:0] mem_addr(input logic [7:0] v);
        logic [11:0] r;
        r = {4'b0, v};
        for (int k = 3; k >= 0; k--) begin
            if (r >= 12'(MEM_DEPTH << k)) begin
                r = r - 12'(MEM_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    assign live     = !i_q_empty;
    assign is_ld    = (i_head.func == tiex_pkg::FUNC_LD);
    assign out_free = !r_out_valid || o_result.ready;
    // A load first reads memory into a register, then completes when out_free is set.
    assign ld_issue = live && is_ld && !r_ld_phase;
    assign fire     = live && (!is_ld || r_ld_phase) && out_free;
    assign o_pop    = fire;
    assign running  = in_window(r_pc, r_start, r_len);

    assign a_val    = i_head.ra_ok ? r_rf[i_head.reg_a[RW-1:0]] : 8'd0;
    assign b_val    = i_head.rb_ok ? r_rf[i_head.reg_b[RW-1:0]] : 8'd0;
    assign addr_src = is_ld ? b_val : a_val;
    assign maddr    = mem_addr(addr_src);
    assign hit      = r_mem_valid[maddr];
    assign ld_val   = r_mem_wr[maddr] ? r_ld_data : 8'd0;
    assign cyc_add  = i_head.is_mem ? (hit ? tiex_pkg::CYC_HIT : tiex_pkg::CYC_MISS)
                                    : tiex_pkg::CYC_ALU;

    always_comb begin
        npc   = r_pc + 1'b1;
        wdata = i_head.imm;
        case (i_head.func)
            tiex_pkg::FUNC_MOV:     wdata = i_head.imm;
            tiex_pkg::FUNC_ADD_REG: wdata = a_val + b_val;
            tiex_pkg::FUNC_ADD_IMM: wdata = a_val + i_head.imm;
            tiex_pkg::FUNC_LD:      wdata = ld_val;
            tiex_pkg::FUNC_JE: begin
                if (r_eq) begin
                    npc = i_head.target;
                end
            end
            tiex_pkg::FUNC_JMP:     npc = i_head.target;
            default:                wdata = i_head.imm;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_exec = r_exec;
        n_cyc  = r_cyc;
        n_hit  = r_hit;
        n_acc  = r_acc;
        if (running) begin
            n_pc   = npc;
            n_exec = r_exec + 1'b1;
            n_cyc  = r_cyc + {{(CN - 6){1'b0}}, cyc_add};
            if (i_head.is_mem) begin
                n_acc = r_acc + 1'b1;
                if (hit) begin
                    n_hit = r_hit + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_start     <= '0;
            r_len       <= '0;
            r_eq        <= 1'b0;
            r_mem_valid <= '0;
            r_mem_wr    <= '0;
            r_exec      <= '0;
            r_cyc       <= '0;
            r_hit       <= '0;
            r_acc       <= '0;
            r_ld_phase  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    tiex_pkg::CFG_PROG_START: begin
                        r_start <= i_cfg.data;
                        r_pc    <= i_cfg.data;
                    end
                    tiex_pkg::CFG_PROG_LENGTH: begin
                        r_len <= i_cfg.data[LW-1:0];
                    end
                    default: begin
                        r_len <= r_len;
                    end
                endcase
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ld_issue) begin
                r_ld_phase <= 1'b1;
            end
            if (fire) begin
                r_ld_phase  <= 1'b0;
                r_pc        <= n_pc;
                r_exec      <= n_exec;
                r_cyc       <= n_cyc;
                r_hit       <= n_hit;
                r_acc       <= n_acc;
                if (running) begin
                    if (i_head.wr_reg) begin
                        r_rf[i_head.reg_a[RW-1:0]] <= wdata;
                    end
                    if (i_head.func == tiex_pkg::FUNC_CMP) begin
                        r_eq <= (a_val == b_val);
                    end
                    if (i_head.is_mem) begin
                        r_mem_valid[maddr] <= 1'b1;
                    end
                    if (i_head.func == tiex_pkg::FUNC_ST) begin
                        r_mem_wr[maddr] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_issue) begin
            r_ld_data <= r_mem_data[maddr];
        end
        if (fire && running && (i_head.func == tiex_pkg::FUNC_ST)) begin
            r_mem_data[maddr] <= b_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pc     <= n_pc;
            r_out_halted <= !in_window(n_pc, r_start, r_len);
            r_out_exec   <= n_exec;
            r_out_cyc    <= n_cyc;
            r_out_hit    <= n_hit;
            r_out_acc    <= n_acc;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.next_pc        = r_out_pc;
    assign o_result.halted         = r_out_halted;
    assign o_result.executed_count = r_out_exec;
    assign o_result.cycle_total    = r_out_cyc;
    assign o_result.hit_count      = r_out_hit;
    assign o_result.access_count   = r_out_acc;

endmodule

`default_nettype wire

// ----- test/tiny_isa_execute_with_local_memory_top_test.sv -----
// Self-checking testbench for the tiny instruction execute block with local memory.
`timescale 1ns / 100ps

module tiny_isa_execute_with_local_memory_top_test;
    import tiex_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 450;

    typedef struct {
        t_func             func;
        logic [2:0]        reg_a;
        logic [2:0]        reg_b;
        logic signed [7:0] imm;
        logic [15:0]       target;
    } t_instr;

    typedef struct {
        logic [15:0] next_pc;
        logic        halted;
        logic [31:0] executed;
        logic [31:0] cycles;
        logic [31:0] hits;
        logic [31:0] accesses;
    } t_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tiex_in_if  item_if();
    tiex_out_if result_if();

    tiny_isa_execute_with_local_memory_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // Machine state as the testbench expects it to be.
    logic [15:0] m_start;
    logic [10:0] m_len;
    logic [15:0] m_pc;
    logic [7:0]  m_regs [REG_COUNT_DEF];
    logic        m_eq;
    logic [7:0]  m_mem [MEM_DEPTH_DEF];
    logic        m_mvalid [MEM_DEPTH_DEF];
    logic [31:0] m_executed;
    logic [31:0] m_cycles;
    logic [31:0] m_hits;
    logic [31:0] m_accesses;

    t_report retire_q[$];
    int      err_count;
    int      idle_cycles;
    bit      calm;
    bit      last_executed;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int window_span();
        return (int'(m_len) > PROG_DEPTH_DEF) ? PROG_DEPTH_DEF : int'(m_len);
    endfunction

    // The window end is not wrapped, so the window never wraps to low addresses.
    function automatic bit in_window(logic [15:0] addr);
        return int'(addr) >= int'(m_start) && int'(addr) < int'(m_start) + window_span();
    endfunction

    function automatic logic [7:0] read_reg(logic [2:0] idx);
        return (int'(idx) < REG_COUNT_DEF) ? m_regs[idx] : 8'd0;
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [7:0] value);
        if (int'(idx) < REG_COUNT_DEF) begin
            m_regs[idx] = value;
        end
    endfunction

    function automatic void touch_mem(logic [7:0] addr);
        int slot;
        slot = int'(addr) % MEM_DEPTH_DEF;
        m_accesses++;
        if (m_mvalid[slot]) begin
            m_hits++;
            m_cycles += 32'(CYC_HIT);
        end else begin
            m_mvalid[slot] = 1'b1;
            m_cycles += 32'(CYC_MISS);
        end
    endfunction

    function automatic void reset_machine();
        m_start    = '0;
        m_len      = '0;
        m_pc       = '0;
        m_eq       = 1'b0;
        m_executed = '0;
        m_cycles   = '0;
        m_hits     = '0;
        m_accesses = '0;
        foreach (m_regs[i]) m_regs[i] = '0;
        foreach (m_mem[i]) begin
            m_mem[i]    = '0;
            m_mvalid[i] = 1'b0;
        end
    endfunction

    // Executes one instruction on the expected machine state and returns its report.
    function automatic t_report retire_instruction(t_instr ins);
        t_report     rep;
        logic [15:0] npc;
        logic [7:0]  addr;
        if (in_window(m_pc)) begin
            npc = m_pc + 16'd1;
            case (ins.func)
                FUNC_MOV: begin
                    write_reg(ins.reg_a, ins.imm);
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_ADD_REG: begin
                    write_reg(ins.reg_a, read_reg(ins.reg_a) + read_reg(ins.reg_b));
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_ADD_IMM: begin
                    write_reg(ins.reg_a, read_reg(ins.reg_a) + ins.imm);
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_CMP: begin
                    m_eq = (read_reg(ins.reg_a) == read_reg(ins.reg_b));
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_JE: begin
                    if (m_eq) begin
                        npc = ins.target;
                    end
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_JMP: begin
                    npc = ins.target;
                    m_cycles += 32'(CYC_ALU);
                end
                FUNC_LD: begin
                    addr = read_reg(ins.reg_b);
                    touch_mem(addr);
                    write_reg(ins.reg_a, m_mem[int'(addr) % MEM_DEPTH_DEF]);
                end
                default: begin
                    addr = read_reg(ins.reg_a);
                    touch_mem(addr);
                    m_mem[int'(addr) % MEM_DEPTH_DEF] = read_reg(ins.reg_b);
                end
            endcase
            m_pc = npc;
            m_executed++;
        end
        rep.next_pc  = m_pc;
        rep.halted   = !in_window(m_pc);
        rep.executed = m_executed;
        rep.cycles   = m_cycles;
        rep.hits     = m_hits;
        rep.accesses = m_accesses;
        return rep;
    endfunction

    function automatic t_instr make_instr(t_func f, int ra, int rb, int imm, int tgt);
        t_instr ins;
        ins.func   = f;
        ins.reg_a  = 3'(ra);
        ins.reg_b  = 3'(rb);
        ins.imm    = 8'(imm);
        ins.target = 16'(tgt);
        return ins;
    endfunction

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PROG_START) begin
            m_start = data;
            m_pc    = data;
        end else begin
            m_len = data[LEN_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Valid is left high after acceptance; the next call either reuses it or drops it.
    task automatic issue_instr(t_instr ins);
        while (!calm && $urandom_range(99) < 28) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.func        <= ins.func;
        item_if.reg_a       <= ins.reg_a;
        item_if.reg_b       <= ins.reg_b;
        item_if.immediate   <= ins.imm;
        item_if.jump_target <= ins.target;
        do @(posedge i_clk); while (!item_if.ready);
        last_executed = in_window(m_pc);
        retire_q.push_back(retire_instruction(ins));
    endtask

    task automatic settle_block();
        item_if.valid <= 1'b0;
        while (retire_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (retire_q.size() == 0) begin
                $error("result transaction with nothing expected, next_pc %0h",
                       result_if.next_pc);
                err_count++;
            end else begin
                want = retire_q.pop_front();
                check_field("next_pc", want.next_pc, result_if.next_pc);
                check_field("halted", want.halted, result_if.halted);
                check_field("executed_count", want.executed, result_if.executed_count);
                check_field("cycle_total", want.cycles, result_if.cycle_total);
                check_field("hit_count", want.hits, result_if.hit_count);
                check_field("access_count", want.accesses, result_if.access_count);
            end
        end
        result_if.ready <= calm || ($urandom_range(99) >= 28);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // With a zero-length window the machine is halted from the start.
    task automatic test_halted_after_reset();
        issue_instr(make_instr(FUNC_MOV, 0, 0, 5, 0));
        settle_block();
    endtask

    task automatic test_alu_and_branch();
        write_cfg(CFG_PROG_LENGTH, 16'd1024);
        write_cfg(CFG_PROG_START, 16'h0100);
        issue_instr(make_instr(FUNC_MOV, 0, 0, 127, 0));
        issue_instr(make_instr(FUNC_MOV, 1, 0, -128, 0));
        issue_instr(make_instr(FUNC_ADD_REG, 0, 1, 0, 0));
        issue_instr(make_instr(FUNC_MOV, 3, 0, -1, 0));
        issue_instr(make_instr(FUNC_ADD_IMM, 3, 0, 1, 0));
        // Register indexes past the end of the file read as zero and drop writes.
        issue_instr(make_instr(FUNC_MOV, 6, 0, 5, 0));
        issue_instr(make_instr(FUNC_ADD_REG, 2, 7, 0, 0));
        issue_instr(make_instr(FUNC_CMP, 0, 0, 0, 0));
        issue_instr(make_instr(FUNC_JE, 0, 0, 0, 16'h0180));
        issue_instr(make_instr(FUNC_CMP, 1, 2, 0, 0));
        issue_instr(make_instr(FUNC_JE, 0, 0, 0, 16'hFFFF));
        issue_instr(make_instr(FUNC_JMP, 0, 0, 0, 16'h0100));
    endtask

    task automatic test_local_memory();
        issue_instr(make_instr(FUNC_MOV, 4, 0, -1, 0));
        issue_instr(make_instr(FUNC_ST, 4, 0, 0, 0));
        issue_instr(make_instr(FUNC_LD, 5, 4, 0, 0));
        // A load miss on a byte never stored reads zero.
        issue_instr(make_instr(FUNC_LD, 1, 2, 0, 0));
        issue_instr(make_instr(FUNC_ST, 7, 6, 0, 0));
        issue_instr(make_instr(FUNC_LD, 7, 4, 0, 0));
        settle_block();
    endtask

    task automatic test_window_edges();
        // A one-slot window at the top address: pc wraps to zero and halts.
        write_cfg(CFG_PROG_LENGTH, 16'd1);
        write_cfg(CFG_PROG_START, 16'hFFFF);
        issue_instr(make_instr(FUNC_MOV, 0, 0, 1, 0));
        issue_instr(make_instr(FUNC_MOV, 1, 0, 2, 0));
        settle_block();
        // Lengths above the program depth are clipped to it.
        write_cfg(CFG_PROG_LENGTH, 16'hFFFF);
        write_cfg(CFG_PROG_START, 16'h0000);
        issue_instr(make_instr(FUNC_JMP, 0, 0, 0, 16'h03FF));
        issue_instr(make_instr(FUNC_MOV, 2, 0, 3, 0));
        settle_block();
        write_cfg(CFG_PROG_START, 16'h0000);
        issue_instr(make_instr(FUNC_CMP, 0, 0, 0, 0));
        issue_instr(make_instr(FUNC_JE, 0, 0, 0, 16'hFFFF));
        settle_block();
    endtask

    // Runs short programs in random windows; most jumps stay inside the window.
    task automatic test_random_programs();
        int     done;
        int     burst;
        int     span;
        int     hi;
        t_instr ins;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            settle_block();
            calm = (done >= 150 && done < 260);
            if ($urandom_range(3) != 0) begin
                if ($urandom_range(7) == 0) begin
                    write_cfg(CFG_PROG_LENGTH, 16'($urandom));
                end else begin
                    write_cfg(CFG_PROG_LENGTH,
                              {5'($urandom), 11'($urandom_range(1024, 16))});
                end
            end
            case ($urandom_range(3))
                0: write_cfg(CFG_PROG_START, 16'h0000);
                1: write_cfg(CFG_PROG_START, 16'($urandom));
                2: write_cfg(CFG_PROG_START, 16'(65535 - $urandom_range(1100)));
                default: write_cfg(CFG_PROG_START, 16'($urandom_range(4095)));
            endcase
            span = window_span();
            hi   = int'(m_start) + span - 1;
            if (hi > 65535) begin
                hi = 65535;
            end
            burst = $urandom_range(60, 10);
            while (burst > 0) begin
                if (!in_window(m_pc)) begin
                    if ($urandom_range(2) == 0) begin
                        issue_instr(make_instr(t_func'($urandom_range(7)), 0, 0, 0, 0));
                    end
                    break;
                end
                ins.func   = t_func'($urandom_range(7));
                ins.reg_a  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                      : 3'($urandom_range(5));
                ins.reg_b  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                      : 3'($urandom_range(5));
                ins.imm    = 8'($urandom);
                ins.target = ($urandom_range(99) < 85) ? 16'($urandom_range(hi, m_start))
                                                       : 16'($urandom);
                issue_instr(ins);
                if (last_executed) begin
                    done++;
                end
                burst--;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_PROG_START;
        cfg_data              = '0;
        item_if.valid         = 1'b0;
        item_if.func          = FUNC_MOV;
        item_if.reg_a         = '0;
        item_if.reg_b         = '0;
        item_if.immediate     = '0;
        item_if.jump_target   = '0;
        result_if.ready       = 1'b0;
        err_count             = 0;
        idle_cycles           = 0;
        calm                  = 1'b0;
        reset_machine();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_halted_after_reset();
        test_alu_and_branch();
        test_local_memory();
        test_window_edges();
        test_random_programs();
        settle_block();

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
